>>> sv/wmed_pkg.sv
// Package for the windowed median filter: constants, word types, controller states and commands.
package wmed_pkg;

    localparam int CHANNELS        = 7;
    localparam int FIELD_BITS      = 32;
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 32;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] temp_sample;
        logic signed [FIELD_BITS-1:0] humid_sample;
        logic signed [FIELD_BITS-1:0] press_sample;
        logic signed [FIELD_BITS-1:0] lux_sample;
        logic signed [FIELD_BITS-1:0] uva_sample;
        logic signed [FIELD_BITS-1:0] uvb_sample;
        logic signed [FIELD_BITS-1:0] uvidx_sample;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] temp_median;
        logic signed [FIELD_BITS-1:0] humid_median;
        logic signed [FIELD_BITS-1:0] press_median;
        logic signed [FIELD_BITS-1:0] lux_median;
        logic signed [FIELD_BITS-1:0] uva_median;
        logic signed [FIELD_BITS-1:0] uvb_median;
        logic signed [FIELD_BITS-1:0] uvidx_median;
    } t_out;

    typedef enum logic [1:0] {
        S_FILL,
        S_HOLD,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic wr_en;  // store the incoming word
        logic acc;    // read data valid, accumulate counts
        logic first;  // first comparand for this candidate
        logic last;   // last comparand for this candidate
    } t_cmd;

endpackage

>>> sv/wmed_ctrl.sv
// Controller for the windowed median filter: fill count, scan sequencer and output valid.
module wmed_ctrl #(
    parameter int WINDOW = wmed_pkg::WINDOW_DEF,
    parameter int IW     = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output wmed_pkg::t_cmd o_cmd,
    output logic [IW-1:0] o_wr_addr,
    output logic [IW-1:0] o_rd_a,
    output logic [IW-1:0] o_rd_b
);

    localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);

    wmed_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_fill, n_fill;
    logic [IW-1:0]    r_i, n_i;
    logic [IW-1:0]    r_j, n_j;
    logic             r_out_valid, n_out_valid;
    logic             r_acc, n_acc;
    logic             r_first, n_first;
    logic             r_last, n_last;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmed_pkg::S_FILL;
            r_fill      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
            r_acc       <= 1'b0;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_first     <= n_first;
            r_last      <= n_last;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        n_acc       = 1'b0;
        n_first     = 1'b0;
        n_last      = 1'b0;
        accept      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wmed_pkg::S_FILL: begin
                accept = i_in_valid;
                if (i_in_valid) begin
                    if (r_fill == LAST_IDX) begin
                        n_fill  = '0;
                        n_state = wmed_pkg::S_HOLD;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            wmed_pkg::S_HOLD: begin
                // result registers are reused, wait until the last word is taken
                if (!r_out_valid) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = wmed_pkg::S_SCAN;
                end
            end
            wmed_pkg::S_SCAN: begin
                n_acc   = 1'b1;
                n_first = (r_j == '0);
                n_last  = (r_j == LAST_IDX);
                if (r_j == LAST_IDX) begin
                    n_j = '0;
                    if (r_i == LAST_IDX) begin
                        n_state = wmed_pkg::S_DRAIN;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            wmed_pkg::S_DRAIN: begin
                n_out_valid = 1'b1;
                n_state     = wmed_pkg::S_FILL;
            end
            default: begin
                n_state = wmed_pkg::S_FILL;
            end
        endcase
    end

    assign o_in_ready  = (r_state == wmed_pkg::S_FILL);
    assign o_out_valid = r_out_valid;
    assign o_cmd.wr_en = accept;
    assign o_cmd.acc   = r_acc;
    assign o_cmd.first = r_first;
    assign o_cmd.last  = r_last;
    assign o_wr_addr   = r_fill;
    assign o_rd_a      = r_i;
    assign o_rd_b      = r_j;

endmodule

>>> sv/wmed_dp.sv
// Datapath for the windowed median filter: window store, rank counters and result registers.
module wmed_dp #(
    parameter int WINDOW      = wmed_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wmed_pkg::SAMPLE_BITS_DEF,
    parameter int IW          = 4
) (
    input  logic           i_clk,
    input  wmed_pkg::t_cmd i_cmd,
    input  logic [IW-1:0]  i_wr_addr,
    input  logic [IW-1:0]  i_rd_a,
    input  logic [IW-1:0]  i_rd_b,
    input  wmed_pkg::t_in  i_sample,
    output wmed_pkg::t_out o_result
);

    localparam int CH = wmed_pkg::CHANNELS;
    localparam int FB = wmed_pkg::FIELD_BITS;
    localparam int SW = (SAMPLE_BITS < FB) ? SAMPLE_BITS : FB;
    localparam int RW = CH * SW;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] RANK = CW'(WINDOW / 2);

    logic [RW-1:0] r_mem [WINDOW];
    logic [RW-1:0] r_rd_a;
    logic [RW-1:0] r_rd_b;
    logic [RW-1:0] wr_row;
    logic [FB-1:0] lane_in [CH];

    logic [CW-1:0]        r_lt  [CH];
    logic [CW-1:0]        r_le  [CH];
    logic signed [SW-1:0] r_res [CH];

    assign lane_in[0] = i_sample.temp_sample;
    assign lane_in[1] = i_sample.humid_sample;
    assign lane_in[2] = i_sample.press_sample;
    assign lane_in[3] = i_sample.lux_sample;
    assign lane_in[4] = i_sample.uva_sample;
    assign lane_in[5] = i_sample.uvb_sample;
    assign lane_in[6] = i_sample.uvidx_sample;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            wr_row[c*SW +: SW] = lane_in[c][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_row;
        end
        r_rd_a <= r_mem[i_rd_a];
        r_rd_b <= r_mem[i_rd_b];
    end

    for (genvar c = 0; c < CH; c++) begin : g_lane
        logic signed [SW-1:0] n_cand;
        logic signed [SW-1:0] n_comp;
        logic [CW-1:0]        n_lt;
        logic [CW-1:0]        n_le;

        assign n_cand = r_rd_a[c*SW +: SW];
        assign n_comp = r_rd_b[c*SW +: SW];
        assign n_lt   = (i_cmd.first ? '0 : r_lt[c]) + CW'(n_comp < n_cand);
        assign n_le   = (i_cmd.first ? '0 : r_le[c]) + CW'(n_comp <= n_cand);

        // candidate sits at the rank when lt <= rank < le
        always_ff @(posedge i_clk) begin
            if (i_cmd.acc) begin
                r_lt[c] <= n_lt;
                r_le[c] <= n_le;
                if (i_cmd.last && (n_lt <= RANK) && (n_le > RANK)) begin
                    r_res[c] <= n_cand;
                end
            end
        end
    end

    assign o_result.temp_median  = FB'(r_res[0]);
    assign o_result.humid_median = FB'(r_res[1]);
    assign o_result.press_median = FB'(r_res[2]);
    assign o_result.lux_median   = FB'(r_res[3]);
    assign o_result.uva_median   = FB'(r_res[4]);
    assign o_result.uvb_median   = FB'(r_res[5]);
    assign o_result.uvidx_median = FB'(r_res[6]);

endmodule

>>> sv/windowed_median_seven_channel.sv
// Seven-channel block median filter: top level joining controller and datapath.
//
// Each accepted word of seven signed samples is written to a window store of WINDOW rows, one
// word per cycle while o_in_ready is high; it is low from the last word of a window until the
// result is presented. After the last word of a window the block finds, for every channel, the
// sample at rank WINDOW/2 in ascending signed order (the upper median for an even window) and
// presents it as one result word; the window then starts empty. The rank search compares every
// stored row against every other through a two-port read of the store, one pair per cycle on
// all seven channels at once. Words of the next window are taken while a result waits; the
// search starts only once the previous result has been taken. Fields are read as SAMPLE_BITS-bit
// signed values and results are sign-extended to 32 bits.
module windowed_median_seven_channel #(
    parameter int WINDOW      = wmed_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wmed_pkg::SAMPLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wmed_pkg::t_in  i_sample,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wmed_pkg::t_out o_result
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    wmed_pkg::t_cmd cmd;
    logic [IW-1:0]  wr_addr;
    logic [IW-1:0]  rd_a;
    logic [IW-1:0]  rd_b;

    wmed_ctrl #(
        .WINDOW (WINDOW),
        .IW     (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    wmed_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IW          (IW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_wr_addr (wr_addr),
        .i_rd_a    (rd_a),
        .i_rd_b    (rd_b),
        .i_sample  (i_sample),
        .o_result  (o_result)
    );

endmodule

>>> verif/windowed_median_seven_channel_tb.sv
// Testbench for the seven-channel windowed median filter: directed table, random words, self-checking.
module windowed_median_seven_channel_tb;

    localparam int WIN             = wmed_pkg::WINDOW_DEF;
    localparam int SBITS           = wmed_pkg::SAMPLE_BITS_DEF;
    localparam int CHANNELS        = wmed_pkg::CHANNELS;
    localparam int FIELD_BITS      = wmed_pkg::FIELD_BITS;
    localparam int N_DIRECTED      = 20;
    localparam int ITEMS_PER_PHASE = 510;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 150;
    localparam int LONG_HOLD       = 600;
    localparam int LONG_HOLD_AT    = 125;

    typedef logic signed [FIELD_BITS-1:0] t_smp;

    localparam t_smp SMP_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};
    localparam t_smp SMP_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};

    typedef struct {
        wmed_pkg::t_in  word;
        bit             typed;
        wmed_pkg::t_out want;
    } t_row;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    wmed_pkg::t_in  i_sample    = '0;
    logic           i_out_ready = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    wmed_pkg::t_out o_result;

    t_smp           win_store [CHANNELS][WIN];
    int             fill_level     = 0;
    wmed_pkg::t_out median_q [$];
    int             mismatch_count = 0;
    int             stall_cycles   = 0;
    int             send_idle_pct  = 0;
    int             recv_idle_pct  = 0;
    int             rx_taken       = 0;
    int             hold_left      = 0;
    bit             hold_done      = 1'b0;
    t_row           dir_rows [N_DIRECTED];
    string chan_name [CHANNELS] = '{"temp", "humid", "press", "lux", "uva", "uvb", "uvidx"};

    windowed_median_seven_channel DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic t_smp sample_of(input wmed_pkg::t_in w, input int c);
        return w[(CHANNELS-1-c)*FIELD_BITS +: FIELD_BITS];
    endfunction

    function automatic t_smp median_of(input wmed_pkg::t_out w, input int c);
        return w[(CHANNELS-1-c)*FIELD_BITS +: FIELD_BITS];
    endfunction

    function automatic t_smp sign_extend(input t_smp raw);
        t_smp tmp;
        if (SBITS >= FIELD_BITS)
            return raw;
        tmp = raw << (FIELD_BITS - SBITS);
        return tmp >>> (FIELD_BITS - SBITS);
    endfunction

    // store one word; on the last word of a window queue the rank WIN/2 word, or want if typed
    task automatic absorb_word(input wmed_pkg::t_in w, input bit typed,
                               input wmed_pkg::t_out want);
        t_smp sorted [WIN];
        t_smp x;
        int   j;
        logic [CHANNELS*FIELD_BITS-1:0] flat;
        if (fill_level >= WIN)
            fill_level = 0;
        for (int c = 0; c < CHANNELS; c++)
            win_store[c][fill_level] = sign_extend(sample_of(w, c));
        fill_level++;
        if (fill_level >= WIN) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int i = 0; i < WIN; i++) begin
                    x = win_store[c][i];
                    j = i;
                    while (j > 0 && sorted[j-1] > x) begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = x;
                end
                flat[(CHANNELS-1-c)*FIELD_BITS +: FIELD_BITS] = sorted[WIN/2];
            end
            fill_level = 0;
            median_q.push_back(typed ? want : wmed_pkg::t_out'(flat));
        end
    endtask

    task automatic send_word(input wmed_pkg::t_in w, input bit typed,
                             input wmed_pkg::t_out want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= w;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_word(w, typed, want);
    endtask

    function automatic wmed_pkg::t_in random_word();
        logic [CHANNELS*FIELD_BITS-1:0] flat;
        t_smp v;
        int   k;
        for (int c = 0; c < CHANNELS; c++) begin
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = t_smp'($urandom_range(16)) - 8;
                2: begin
                    k = $urandom_range(3);
                    v = (k == 0) ? SMP_MIN : (k == 1) ? SMP_MAX : (k == 2) ? '0 : '1;
                end
                default: v = t_smp'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
            endcase
            flat[(CHANNELS-1-c)*FIELD_BITS +: FIELD_BITS] = v;
        end
        return wmed_pkg::t_in'(flat);
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                rx_taken = rx_taken + 1;
            if (!hold_done && rx_taken == LONG_HOLD_AT) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left   = hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        wmed_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", o_result));
            end else begin
                want = median_q.pop_front();
                for (int c = 0; c < CHANNELS; c++)
                    if (median_of(o_result, c) !== median_of(want, c))
                        report_mismatch($sformatf("%s_median got %h want %h", chan_name[c],
                                                  median_of(o_result, c), median_of(want, c)));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        wmed_pkg::t_in tie_word;
        tie_word = wmed_pkg::t_in'({t_smp'(-1), t_smp'(0), t_smp'(1), SMP_MIN, SMP_MAX,
                                    t_smp'(32'h0001_0000), t_smp'(32'hFFFF_0000)});
        // window of alternating extremes, then a window of ties per channel
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (r < WIN) begin
                dir_rows[r].word  = wmed_pkg::t_in'((r % 2) ? {CHANNELS{SMP_MAX}}
                                                            : {CHANNELS{SMP_MIN}});
                dir_rows[r].typed = (r == WIN - 1);
                dir_rows[r].want  = wmed_pkg::t_out'({CHANNELS{SMP_MAX}});
            end else begin
                dir_rows[r].word  = tie_word;
                dir_rows[r].typed = (r == N_DIRECTED - 1);
                dir_rows[r].want  = wmed_pkg::t_out'(tie_word);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 81;
        for (int r = 0; r < N_DIRECTED; r++)
            send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase > 0) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (median_q.size() != 0);
            end
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 27 : 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_word(random_word(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (median_q.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", median_q.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
